FILE: hw/rtl/period_vwap_accumulator_unit_macros.svh
// Assertion helpers shared by the checkers of the VWAP accumulator.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef PERIOD_VWAP_ACCUMULATOR_UNIT_MACROS_SVH
`define PERIOD_VWAP_ACCUMULATOR_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset
`define PVA_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication
`define PVA_ASSERT_IMPLY(lbl, ante, cons, msg) \
	`PVA_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	`PVA_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

FILE: hw/rtl/pva_pkg.sv
`default_nettype none

package pva_pkg;

	// Fixed field and accumulator widths
	localparam int WSUM_W  = 64;
	localparam int VSUM_W  = 48;
	localparam int VOL_W   = 32;
	localparam int TIME_W  = 17;
	localparam int WDAY_W  = 3;
	localparam int MONTH_W = 4;
	localparam int MDAY_W  = 5;
	localparam int VWAP_W  = 32;

	// Reset values of configuration and previous-bar state
	localparam logic [TIME_W-1:0]  SESSION_CLOSE_RST = 17'd64800;
	localparam logic [MONTH_W-1:0] MONTH_RST         = 4'd1;

	// Front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified bar, as the back end consumes it
	typedef struct packed {
		logic              first;
		logic              tod_hit;
		logic              month_change;
		logic              week_drop;
		logic              first_week_part;
		logic              first_month_part;
		logic [WSUM_W-1:0] weight;
		logic [VOL_W-1:0]  volume;
	} item_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ADD,
		BK_DECIDE,
		BK_SEL,
		BK_DIV,
		BK_FINISH
	} back_state_t;

	typedef enum logic [1:0] {
		PER_DAY,
		PER_WEEK,
		PER_MONTH
	} period_t;

	// Last calendar day of each month; no month end outside 1..12
	function automatic logic is_month_end(input logic [MONTH_W-1:0] month,
			input logic [MDAY_W-1:0] mday);
		logic [MDAY_W-1:0] last_day;
		logic              known;
		known = 1'b1;
		case (month)
			4'd1:    last_day = 5'd31;
			4'd2:    last_day = 5'd28;
			4'd3:    last_day = 5'd31;
			4'd4:    last_day = 5'd30;
			4'd5:    last_day = 5'd31;
			4'd6:    last_day = 5'd30;
			4'd7:    last_day = 5'd31;
			4'd8:    last_day = 5'd31;
			4'd9:    last_day = 5'd30;
			4'd10:   last_day = 5'd31;
			4'd11:   last_day = 5'd30;
			4'd12:   last_day = 5'd31;
			default: begin
				last_day = 5'd0;
				known    = 1'b0;
			end
		endcase
		return known && (mday == last_day);
	endfunction

	// Saturating accumulate of a weighted sum
	function automatic logic [WSUM_W-1:0] sat_add_w(input logic [WSUM_W-1:0] a,
			input logic [WSUM_W-1:0] b);
		logic [WSUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[WSUM_W] ? {WSUM_W{1'b1}} : s[WSUM_W-1:0];
	endfunction

	// Saturating accumulate of a volume sum
	function automatic logic [VSUM_W-1:0] sat_add_v(input logic [VSUM_W-1:0] a,
			input logic [VOL_W-1:0] b);
		logic [VSUM_W:0] s;
		s = {1'b0, a} + (VSUM_W + 1)'(b);
		return s[VSUM_W] ? {VSUM_W{1'b1}} : s[VSUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pva_front.sv
`default_nettype none

module pva_front import pva_pkg::*; #(
	parameter int PRICE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PRICE_BITS-1:0] bar_high,
	input  logic [PRICE_BITS-1:0] bar_low,
	input  logic [VOL_W-1:0]      bar_volume,
	input  logic [TIME_W-1:0]     time_of_day,
	input  logic [WDAY_W-1:0]     day_of_week,
	input  logic [MONTH_W-1:0]    month_number,
	input  logic [MDAY_W-1:0]     day_of_month,
	input  logic                  first_bar,
	input  logic                  no_settlement,
	input  logic [TIME_W-1:0]     close_time,
	output logic                  q_push,
	output item_t                 q_item,
	input  logic                  q_full
);

	localparam int HL_W   = PRICE_BITS + 1;
	localparam int PROD_W = HL_W + VOL_W;

	logic [PRICE_BITS-1:0] prev_high_q;
	logic [PRICE_BITS-1:0] prev_low_q;
	logic [VOL_W-1:0]      prev_vol_q;
	logic [TIME_W-1:0]     prev_time_q;
	logic [WDAY_W-1:0]     prev_wday_q;
	logic [MONTH_W-1:0]    prev_month_q;

	logic                  valid_s1;
	logic                  first_s1;
	logic                  tod_hit_s1;
	logic                  mchg_s1;
	logic                  wdrop_s1;
	logic                  fwp_s1;
	logic                  fmp_s1;
	logic [HL_W-1:0]       hl_s1;
	logic [VOL_W-1:0]      vol_s1;

	logic                  accept;
	logic                  month_end;
	logic [PROD_W-1:0]     prod;
	logic [WSUM_W-1:0]     weight;

	// Handshake: stage one drains into the queue
	assign q_push   = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	assign month_end = is_month_end(month_number, day_of_month);

	// Track stage one occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !q_push);
		end
	end

	// Hold the previous bar for the next classification
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_high_q  <= '0;
			prev_low_q   <= '0;
			prev_vol_q   <= '0;
			prev_time_q  <= '0;
			prev_wday_q  <= '0;
			prev_month_q <= MONTH_RST;
		end else if (accept) begin
			prev_high_q  <= bar_high;
			prev_low_q   <= bar_low;
			prev_vol_q   <= bar_volume;
			prev_time_q  <= time_of_day;
			prev_wday_q  <= day_of_week;
			prev_month_q <= month_number;
		end
	end

	// Classify the bar against the previous one
	always_ff @(posedge clk) begin
		if (accept) begin
			first_s1   <= first_bar;
			tod_hit_s1 <= (time_of_day == close_time) && (prev_time_q != close_time) &&
				!no_settlement;
			mchg_s1    <= month_end || (month_number != prev_month_q);
			wdrop_s1   <= day_of_week < prev_wday_q;
			fwp_s1     <= day_of_week != '0;
			fmp_s1     <= !month_end;
			hl_s1      <= HL_W'(prev_high_q) + HL_W'(prev_low_q);
			vol_s1     <= prev_vol_q;
		end
	end

	// Weight of the previous bar, saturated to the accumulator width
	assign prod = PROD_W'(hl_s1) * PROD_W'(vol_s1);

	if (PROD_W > WSUM_W) begin : g_sat
		assign weight = (|prod[PROD_W-1:WSUM_W]) ? {WSUM_W{1'b1}} : prod[WSUM_W-1:0];
	end else begin : g_ext
		assign weight = WSUM_W'(prod);
	end

	always_comb begin
		q_item.first            = first_s1;
		q_item.tod_hit          = tod_hit_s1;
		q_item.month_change     = mchg_s1;
		q_item.week_drop        = wdrop_s1;
		q_item.first_week_part  = fwp_s1;
		q_item.first_month_part = fmp_s1;
		q_item.weight           = weight;
		q_item.volume           = vol_s1;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pva_queue.sv
`default_nettype none

module pva_queue import pva_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = cnt_q == QCNT_W'(QDEPTH);
	assign empty    = cnt_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pva_div.sv
`default_nettype none

module pva_div import pva_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WSUM_W-1:0] dividend,
	input  logic [VSUM_W-1:0] volume,
	output logic              done,
	output logic [VWAP_W-1:0] quot
);

	localparam int NUM_W = WSUM_W + FRACTION_BITS;
	localparam int DEN_W = VSUM_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [VWAP_W-1:0] qlo_q;
	logic              ovf_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0]    rem_sh;
	logic [DEN_W+1:0]  diff;
	logic              ge;
	logic [DEN_W-1:0]  rem_next;

	// One restoring step: shift in a dividend bit, subtract when it fits
	assign rem_sh   = {rem_q, num_q[NUM_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, den_q};
	assign ge       = !diff[DEN_W+1];
	assign rem_next = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

	// Quotient above the 32-bit range saturates
	assign quot = ovf_q ? {VWAP_W{1'b1}} : qlo_q;
	assign done = done_q;

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Load operands, then shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(dividend) << FRACTION_BITS;
			den_q <= {volume, 1'b0};
			rem_q <= '0;
			qlo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_next;
			qlo_q <= {qlo_q[VWAP_W-2:0], ge};
			ovf_q <= ovf_q | qlo_q[VWAP_W-1];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pva_back.sv
`default_nettype none

module pva_back import pva_pkg::*; #(
	parameter int FRACTION_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VWAP_W-1:0] vwap_day,
	output logic [VWAP_W-1:0] vwap_week,
	output logic [VWAP_W-1:0] vwap_month,
	output logic              day_closed,
	output logic              week_closed,
	output logic              month_closed
);

	back_state_t       state_q;
	back_state_t       state_nx;
	item_t             e_q;

	logic [WSUM_W-1:0] dws_q, wws_q, mws_q;
	logic [VSUM_W-1:0] dvs_q, wvs_q, mvs_q;
	logic              wpart_q, mpart_q;
	logic [VWAP_W-1:0] held_day_q, held_week_q, held_month_q;
	logic              dclose_q, wclose_q, mclose_q;
	logic              pend_day_q, pend_week_q, pend_month_q;
	period_t           tgt_q;

	logic              out_valid_q;
	logic [VWAP_W-1:0] out_day_q, out_week_q, out_month_q;
	logic              out_dc_q, out_wc_q, out_mc_q;

	logic              slot_free;
	logic              any_pend;
	logic              div_start;
	logic              load_out;
	period_t           sel_per;
	logic [WSUM_W-1:0] div_num;
	logic [VSUM_W-1:0] div_vol;
	logic              div_done;
	logic [VWAP_W-1:0] div_quot;

	logic              dclose, wclose, mclose, wdiv, mdiv;

	// Shared serial divider for all three periods
	pva_div #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.volume  (div_vol),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign slot_free = !out_valid_q || !out_stall;
	assign any_pend  = pend_day_q || pend_week_q || pend_month_q;

	// Close decisions on the freshly accumulated sums
	assign dclose = e_q.tod_hit && (dvs_q != '0);
	assign mclose = dclose && e_q.month_change;
	assign wclose = e_q.week_drop && ((wvs_q != '0) || wpart_q);
	assign wdiv   = wclose && !wpart_q && (wvs_q != '0);
	assign mdiv   = mclose && !mpart_q && (mvs_q != '0);

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_nx = BK_ADD;
				end
			end
			BK_ADD: begin
				state_nx = e_q.first ? BK_FINISH : BK_DECIDE;
			end
			BK_DECIDE: begin
				state_nx = BK_SEL;
			end
			BK_SEL: begin
				state_nx = any_pend ? BK_DIV : BK_FINISH;
			end
			BK_DIV: begin
				if (div_done) begin
					state_nx = BK_SEL;
				end
			end
			BK_FINISH: begin
				if (slot_free) begin
					state_nx = BK_IDLE;
				end
			end
			default: begin
				state_nx = BK_IDLE;
			end
		endcase
	end

	// State outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			BK_IDLE:   q_pop     = !q_empty;
			BK_SEL:    div_start = any_pend;
			BK_FINISH: load_out  = slot_free;
			default: begin
			end
		endcase
	end

	// Pick the next pending division, day first
	always_comb begin
		if (pend_day_q) begin
			sel_per = PER_DAY;
		end else if (pend_week_q) begin
			sel_per = PER_WEEK;
		end else begin
			sel_per = PER_MONTH;
		end
		case (sel_per)
			PER_DAY: begin
				div_num = dws_q;
				div_vol = dvs_q;
			end
			PER_WEEK: begin
				div_num = wws_q;
				div_vol = wvs_q;
			end
			default: begin
				div_num = mws_q;
				div_vol = mvs_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Latch the popped item
	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_q <= q_item;
		end
	end

	// Period sums, partial flags and held values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dws_q        <= '0;
			wws_q        <= '0;
			mws_q        <= '0;
			dvs_q        <= '0;
			wvs_q        <= '0;
			mvs_q        <= '0;
			wpart_q      <= 1'b1;
			mpart_q      <= 1'b1;
			held_day_q   <= '0;
			held_week_q  <= '0;
			held_month_q <= '0;
			dclose_q     <= 1'b0;
			wclose_q     <= 1'b0;
			mclose_q     <= 1'b0;
			pend_day_q   <= 1'b0;
			pend_week_q  <= 1'b0;
			pend_month_q <= 1'b0;
			tgt_q        <= PER_DAY;
		end else begin
			case (state_q)
				BK_ADD: begin
					dclose_q <= 1'b0;
					wclose_q <= 1'b0;
					mclose_q <= 1'b0;
					if (e_q.first) begin
						dws_q        <= '0;
						wws_q        <= '0;
						mws_q        <= '0;
						dvs_q        <= '0;
						wvs_q        <= '0;
						mvs_q        <= '0;
						wpart_q      <= e_q.first_week_part;
						mpart_q      <= e_q.first_month_part;
						held_day_q   <= '0;
						held_week_q  <= '0;
						held_month_q <= '0;
					end else begin
						dws_q <= sat_add_w(dws_q, e_q.weight);
						wws_q <= sat_add_w(wws_q, e_q.weight);
						mws_q <= sat_add_w(mws_q, e_q.weight);
						dvs_q <= sat_add_v(dvs_q, e_q.volume);
						wvs_q <= sat_add_v(wvs_q, e_q.volume);
						mvs_q <= sat_add_v(mvs_q, e_q.volume);
					end
				end
				BK_DECIDE: begin
					dclose_q     <= dclose;
					wclose_q     <= wclose;
					mclose_q     <= mclose;
					pend_day_q   <= dclose;
					pend_week_q  <= wdiv;
					pend_month_q <= mdiv;
					// Closes that publish zero need no divide
					if (wclose && !wdiv) begin
						held_week_q <= '0;
						wws_q       <= '0;
						wvs_q       <= '0;
						wpart_q     <= 1'b0;
					end
					if (mclose && !mdiv) begin
						held_month_q <= '0;
						mws_q        <= '0;
						mvs_q        <= '0;
						mpart_q      <= 1'b0;
					end
				end
				BK_SEL: begin
					if (div_start) begin
						tgt_q <= sel_per;
						case (sel_per)
							PER_DAY: begin
								dws_q      <= '0;
								dvs_q      <= '0;
								pend_day_q <= 1'b0;
							end
							PER_WEEK: begin
								wws_q       <= '0;
								wvs_q       <= '0;
								wpart_q     <= 1'b0;
								pend_week_q <= 1'b0;
							end
							default: begin
								mws_q        <= '0;
								mvs_q        <= '0;
								mpart_q      <= 1'b0;
								pend_month_q <= 1'b0;
							end
						endcase
					end
				end
				BK_DIV: begin
					if (div_done) begin
						case (tgt_q)
							PER_DAY:  held_day_q   <= div_quot;
							PER_WEEK: held_week_q  <= div_quot;
							default:  held_month_q <= div_quot;
						endcase
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_day_q   <= held_day_q;
			out_week_q  <= held_week_q;
			out_month_q <= held_month_q;
			out_dc_q    <= dclose_q;
			out_wc_q    <= wclose_q;
			out_mc_q    <= mclose_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign vwap_day     = out_day_q;
	assign vwap_week    = out_week_q;
	assign vwap_month   = out_month_q;
	assign day_closed   = out_dc_q;
	assign week_closed  = out_wc_q;
	assign month_closed = out_mc_q;

endmodule

`default_nettype wire

FILE: hw/rtl/period_vwap_accumulator_unit.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    bar_high .. no_settlement
// out      output     out_valid / out_stall  vwap_day .. month_closed
// cfg      input      cfg_valid / cfg_ready  session_close_seconds
//
// The back end walks a bar with no divide through idle, add, decide, select and
// finish, and a first bar through idle, add and finish. Each published VWAP with
// nonzero volume adds a pass through the shared one-bit-per-cycle restoring divider.
// Reset clears all sums and held values and loads a close time of 64800 s.
// The front takes a bar into its stage while the back works; in_stall rises
// only when that stage and the two-entry queue are full. out_stall holds the result.
`default_nettype none

module period_vwap_accumulator_unit import pva_pkg::*; #(
	parameter int PRICE_BITS    = 24,
	parameter int FRACTION_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PRICE_BITS-1:0] bar_high,
	input  logic [PRICE_BITS-1:0] bar_low,
	input  logic [VOL_W-1:0]      bar_volume,
	input  logic [TIME_W-1:0]     time_of_day,
	input  logic [WDAY_W-1:0]     day_of_week,
	input  logic [MONTH_W-1:0]    month_number,
	input  logic [MDAY_W-1:0]     day_of_month,
	input  logic                  first_bar,
	input  logic                  no_settlement,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VWAP_W-1:0]     vwap_day,
	output logic [VWAP_W-1:0]     vwap_week,
	output logic [VWAP_W-1:0]     vwap_month,
	output logic                  day_closed,
	output logic                  week_closed,
	output logic                  month_closed,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [TIME_W-1:0]     session_close_seconds
);

	logic [TIME_W-1:0] close_time_q;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	item_t             push_item;
	item_t             pop_item;

	// Session close register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_time_q <= SESSION_CLOSE_RST;
		end else if (cfg_valid && cfg_ready) begin
			close_time_q <= session_close_seconds;
		end
	end

	pva_front #(
		.PRICE_BITS(PRICE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.bar_high     (bar_high),
		.bar_low      (bar_low),
		.bar_volume   (bar_volume),
		.time_of_day  (time_of_day),
		.day_of_week  (day_of_week),
		.month_number (month_number),
		.day_of_month (day_of_month),
		.first_bar    (first_bar),
		.no_settlement(no_settlement),
		.close_time   (close_time_q),
		.q_push       (q_push),
		.q_item       (push_item),
		.q_full       (q_full)
	);

	pva_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.pop_item (pop_item),
		.empty    (q_empty)
	);

	pva_back #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_item      (pop_item),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.vwap_day    (vwap_day),
		.vwap_week   (vwap_week),
		.vwap_month  (vwap_month),
		.day_closed  (day_closed),
		.week_closed (week_closed),
		.month_closed(month_closed)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/pva_checker.sv
`default_nettype none
`include "period_vwap_accumulator_unit_macros.svh"

module pva_checker import pva_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [VWAP_W-1:0] vwap_day,
	input wire logic [VWAP_W-1:0] vwap_week,
	input wire logic [VWAP_W-1:0] vwap_month,
	input wire logic              day_closed,
	input wire logic              week_closed,
	input wire logic              month_closed
);

	// Stage, queue, back end and result register together
	localparam logic [2:0] MAX_IN_FLIGHT = 3'd5;

	logic       in_xfer;
	logic       out_xfer;
	logic [2:0] flight_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// Count bars taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
		end else begin
			flight_q <= flight_q + 3'(in_xfer) - 3'(out_xfer);
		end
	end

	`PVA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(vwap_day) && $stable(vwap_week) && $stable(vwap_month) && $stable(day_closed) && $stable(week_closed) && $stable(month_closed), "stalled result changed")
	`PVA_ASSERT_IMPLY(a_month_needs_day, out_valid && month_closed, day_closed, "month close without session close")
	`PVA_ASSERT_IMPLY(a_no_invented, out_valid, flight_q != 3'd0, "result without an outstanding bar")
	`PVA_ASSERT_CLK(a_flight_bound, flight_q <= MAX_IN_FLIGHT, "more bars in flight than storage")

endmodule

bind period_vwap_accumulator_unit pva_checker u_pva_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.vwap_day    (vwap_day),
	.vwap_week   (vwap_week),
	.vwap_month  (vwap_month),
	.day_closed  (day_closed),
	.week_closed (week_closed),
	.month_closed(month_closed)
);

`default_nettype wire
